/* sv/page_frame_pool_manager_assert.svh */
// assertion macros shared by the pool manager modules
`ifndef PAGE_FRAME_POOL_MANAGER_ASSERT_SVH
`define PAGE_FRAME_POOL_MANAGER_ASSERT_SVH

// a condition that must hold at every clock edge outside reset
`define PFPM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// an antecedent that implies a consequent in the next cycle
`define PFPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pfpm_pkg.sv */
// ----------------------------------------------------------------------------
// pfpm_pkg
// shared types and command codes of the page frame pool manager
// ----------------------------------------------------------------------------
`default_nettype none

package pfpm_pkg;

    localparam int PAGE_W = 31;
    localparam int FRAME_W = 6;
    localparam int CMD_W = 3;

    localparam logic [CMD_W-1:0] CMD_FETCH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_NEW = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UNPIN = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FLUSH_ALL = 3'd5;

    localparam logic CFG_INSTANCE_COUNT = 1'b0;
    localparam logic CFG_INSTANCE_NUMBER = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic latch;     // capture request
        logic lookup;    // register page lookup and victim search
        logic execute;   // apply the request, emit result
        logic scan_step; // emit one flush-all result at scan position
        logic scan_init; // reset scan position
    } pfpm_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_flush_all;
        logic scan_done;
    } pfpm_stat_t;

endpackage

`default_nettype wire

/* sv/pfpm_ctrl.sv */
// ----------------------------------------------------------------------------
// pfpm_ctrl
// sequencer of the pool manager: accept, lookup, execute or flush-all scan
// ----------------------------------------------------------------------------
`default_nettype none

module pfpm_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    output pfpm_pkg::pfpm_cmd_t   cmd,
    input  pfpm_pkg::pfpm_stat_t  stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_EXEC,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                cmd.scan_init = 1'b1;
                state_next = stat.is_flush_all ? S_SCAN : S_EXEC;
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `include "page_frame_pool_manager_assert.svh"

    `PFPM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not go busy")
    `PFPM_ASSERT_ALWAYS(a_one_phase, $onehot0({cmd.latch, cmd.execute, cmd.scan_step}),
        "more than one phase active")
    `PFPM_ASSERT_NEXT(a_exec_idle, cmd.execute, !busy, "execute not followed by idle")

endmodule

`default_nettype wire

/* sv/pfpm_dp.sv */
// ----------------------------------------------------------------------------
// pfpm_dp
// frame table, free queue, lru ranks and result register of the pool manager
// ----------------------------------------------------------------------------
`default_nettype none

module pfpm_dp #(
    parameter int FRAME_COUNT = 16,
    parameter int PIN_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  pfpm_pkg::pfpm_cmd_t                cmd,
    output pfpm_pkg::pfpm_stat_t               stat,
    input  wire logic                          cfg_write,
    input  wire logic                          cfg_index,
    input  wire logic [10:0]                   cfg_data,
    input  wire logic [pfpm_pkg::CMD_W-1:0]    command,
    input  wire logic [pfpm_pkg::PAGE_W-1:0]   page_number,
    input  wire logic                          mark_dirty,
    output logic                               done,
    output logic                               success,
    output logic [pfpm_pkg::FRAME_W-1:0]       frame_index,
    output logic [pfpm_pkg::PAGE_W-1:0]        result_page,
    output logic                               write_back,
    output logic [pfpm_pkg::PAGE_W-1:0]        write_back_page,
    output logic                               load_from_disk,
    output logic                               clear_frame,
    output logic                               last
);

    localparam int FI_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int CNT_W = $clog2(FRAME_COUNT + 1);
    localparam int AGE_W = CNT_W;
    localparam int PW = pfpm_pkg::PAGE_W;
    localparam int FW = pfpm_pkg::FRAME_W;
    localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

    logic [PW-1:0]       page_reg [FRAME_COUNT];
    logic [FRAME_COUNT-1:0] valid_reg;
    logic [FRAME_COUNT-1:0] dirty_reg;
    logic [PIN_BITS-1:0] pins_reg [FRAME_COUNT];
    logic [AGE_W-1:0]    age_reg [FRAME_COUNT];
    logic [FRAME_COUNT-1:0] member_reg;
    logic [FI_W-1:0]     fq_reg [FRAME_COUNT];
    logic [FI_W-1:0]     fq_head_reg;
    logic [CNT_W-1:0]    fq_count_reg;
    logic [PW-1:0]       next_id_reg;
    logic [10:0]         inst_count_reg;

    logic [pfpm_pkg::CMD_W-1:0] op_reg;
    logic [PW-1:0]       pg_reg;
    logic                md_reg;
    logic                hit_reg;
    logic [FI_W-1:0]     hit_idx_reg;
    logic                vic_ok_reg;
    logic [FI_W-1:0]     vic_idx_reg;
    logic [FI_W-1:0]     scan_reg;

    // result register
    logic                done_reg;
    logic                ok_reg;
    logic [FW-1:0]       fi_reg;
    logic [PW-1:0]       rp_reg;
    logic                wb_reg;
    logic [PW-1:0]       wbp_reg;
    logic                ld_reg;
    logic                clr_reg;
    logic                last_reg;

    // lookup compares (lowest index wins) and victim search
    logic                hit_c;
    logic [FI_W-1:0]     hit_idx_c;
    logic                vic_ok_c;
    logic [FI_W-1:0]     vic_idx_c;

    always_comb
    begin
        hit_c = 1'b0;
        hit_idx_c = '0;
        vic_ok_c = 1'b0;
        vic_idx_c = '0;
        for (int i = FRAME_COUNT - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && page_reg[i] == pg_reg)
            begin
                hit_c = 1'b1;
                hit_idx_c = FI_W'(i);
            end
            if (member_reg[i] && age_reg[i] == '0)
            begin
                vic_ok_c = 1'b1;
                vic_idx_c = FI_W'(i);
            end
        end
    end

    // remaining valid frames above the scan position
    logic                more_c;
    always_comb
    begin
        more_c = 1'b0;
        for (int i = 0; i < FRAME_COUNT; i++)
        begin
            if (valid_reg[i] && FI_W'(i) > scan_reg)
            begin
                more_c = 1'b1;
            end
        end
    end

    logic any_valid_c;
    assign any_valid_c = |valid_reg;
    logic scan_at_end;
    assign scan_at_end = !more_c;
    assign stat.is_flush_all = (op_reg == pfpm_pkg::CMD_FLUSH_ALL);
    assign stat.scan_done = scan_at_end;

    // derived execute decisions
    logic          is_alloc;
    logic          use_free;
    logic          grab_ok;
    logic [FI_W-1:0] grab_idx;
    logic [FI_W-1:0] fq_head_next_c;
    logic [PW-1:0]   alloc_page;

    assign is_alloc = (op_reg == pfpm_pkg::CMD_NEW) ||
                      (op_reg == pfpm_pkg::CMD_FETCH && !hit_reg);
    assign use_free = (fq_count_reg != '0);
    assign grab_ok = use_free || vic_ok_reg;
    assign grab_idx = use_free ? fq_reg[fq_head_reg] : vic_idx_reg;
    assign fq_head_next_c = (fq_head_reg == FI_W'(FRAME_COUNT - 1)) ? '0 : fq_head_reg + 1'b1;
    assign alloc_page = (op_reg == pfpm_pkg::CMD_NEW) ? next_id_reg : pg_reg;

    // lru removal of frame f: members newer than f (higher rank) step down
    function automatic logic [AGE_W-1:0] age_after_take(
        input logic [AGE_W-1:0] a, input logic m, input logic [AGE_W-1:0] af);
        age_after_take = (m && a > af) ? a - 1'b1 : a;
    endfunction

    logic [CNT_W-1:0] member_cnt_c;
    always_comb
    begin
        member_cnt_c = '0;
        for (int i = 0; i < FRAME_COUNT; i++)
        begin
            member_cnt_c = member_cnt_c + CNT_W'(member_reg[i]);
        end
    end

    logic [FI_W-1:0] fq_tail_c;
    logic [FI_W:0]   tail_sum_c;
    assign tail_sum_c = {1'b0, fq_head_reg} + (FI_W+1)'(fq_count_reg);
    assign fq_tail_c = (tail_sum_c >= (FI_W+1)'(FRAME_COUNT)) ?
                       FI_W'(tail_sum_c - (FI_W+1)'(FRAME_COUNT)) : FI_W'(tail_sum_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            member_reg <= '0;
            fq_head_reg <= '0;
            fq_count_reg <= CNT_W'(FRAME_COUNT);
            next_id_reg <= '0;
            inst_count_reg <= 11'd1;
            done_reg <= 1'b0;
            ok_reg <= 1'b0;
            fi_reg <= '0;
            rp_reg <= '0;
            wb_reg <= 1'b0;
            wbp_reg <= '0;
            ld_reg <= 1'b0;
            clr_reg <= 1'b0;
            last_reg <= 1'b0;
            for (int i = 0; i < FRAME_COUNT; i++)
            begin
                page_reg[i] <= '0;
                pins_reg[i] <= '0;
                age_reg[i] <= '0;
                fq_reg[i] <= FI_W'(i);
            end
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_write)
            begin
                if (cfg_index == pfpm_pkg::CFG_INSTANCE_COUNT)
                begin
                    inst_count_reg <= cfg_data;
                end
                else
                begin
                    next_id_reg <= PW'(cfg_data[9:0]);
                end
            end
            if (cmd.execute)
            begin
                done_reg <= 1'b1;
                ok_reg <= 1'b0;
                fi_reg <= '0;
                rp_reg <= '0;
                wb_reg <= 1'b0;
                wbp_reg <= '0;
                ld_reg <= 1'b0;
                clr_reg <= 1'b0;
                last_reg <= 1'b1;
                if (op_reg == pfpm_pkg::CMD_NEW)
                begin
                    next_id_reg <= next_id_reg + PW'(inst_count_reg);
                end
                if (is_alloc)
                begin
                    if (grab_ok)
                    begin
                        ok_reg <= 1'b1;
                        fi_reg <= FW'(grab_idx);
                        rp_reg <= alloc_page;
                        ld_reg <= (op_reg == pfpm_pkg::CMD_FETCH);
                        clr_reg <= (op_reg == pfpm_pkg::CMD_NEW);
                        page_reg[grab_idx] <= alloc_page;
                        valid_reg[grab_idx] <= 1'b1;
                        dirty_reg[grab_idx] <= 1'b0;
                        pins_reg[grab_idx] <= PIN_BITS'(1);
                        if (use_free)
                        begin
                            fq_head_reg <= fq_head_next_c;
                            fq_count_reg <= fq_count_reg - 1'b1;
                        end
                        else
                        begin
                            wb_reg <= dirty_reg[vic_idx_reg];
                            wbp_reg <= dirty_reg[vic_idx_reg] ? page_reg[vic_idx_reg] : '0;
                            for (int i = 0; i < FRAME_COUNT; i++)
                            begin
                                age_reg[i] <= age_after_take(age_reg[i], member_reg[i],
                                                             age_reg[vic_idx_reg]);
                            end
                            member_reg[vic_idx_reg] <= 1'b0;
                            age_reg[vic_idx_reg] <= '0;
                        end
                    end
                end
                else
                begin
                    case (op_reg)
                        pfpm_pkg::CMD_FETCH:
                        begin
                            ok_reg <= 1'b1;
                            fi_reg <= FW'(hit_idx_reg);
                            rp_reg <= pg_reg;
                            if (pins_reg[hit_idx_reg] != PIN_MAX)
                            begin
                                pins_reg[hit_idx_reg] <= pins_reg[hit_idx_reg] + 1'b1;
                            end
                            if (member_reg[hit_idx_reg])
                            begin
                                for (int i = 0; i < FRAME_COUNT; i++)
                                begin
                                    age_reg[i] <= age_after_take(age_reg[i], member_reg[i],
                                                                 age_reg[hit_idx_reg]);
                                end
                                member_reg[hit_idx_reg] <= 1'b0;
                                age_reg[hit_idx_reg] <= '0;
                            end
                        end
                        pfpm_pkg::CMD_UNPIN:
                        begin
                            if (hit_reg)
                            begin
                                fi_reg <= FW'(hit_idx_reg);
                                rp_reg <= pg_reg;
                                if (md_reg)
                                begin
                                    dirty_reg[hit_idx_reg] <= 1'b1;
                                end
                                if (pins_reg[hit_idx_reg] != '0)
                                begin
                                    ok_reg <= 1'b1;
                                    pins_reg[hit_idx_reg] <= pins_reg[hit_idx_reg] - 1'b1;
                                    if (pins_reg[hit_idx_reg] == PIN_BITS'(1) &&
                                        !member_reg[hit_idx_reg])
                                    begin
                                        member_reg[hit_idx_reg] <= 1'b1;
                                        age_reg[hit_idx_reg] <= member_cnt_c;
                                    end
                                end
                            end
                        end
                        pfpm_pkg::CMD_DELETE:
                        begin
                            if (!hit_reg)
                            begin
                                ok_reg <= 1'b1;
                            end
                            else if (pins_reg[hit_idx_reg] != '0)
                            begin
                                fi_reg <= FW'(hit_idx_reg);
                                rp_reg <= pg_reg;
                            end
                            else
                            begin
                                ok_reg <= 1'b1;
                                fi_reg <= FW'(hit_idx_reg);
                                wb_reg <= dirty_reg[hit_idx_reg];
                                wbp_reg <= dirty_reg[hit_idx_reg] ? pg_reg : '0;
                                clr_reg <= 1'b1;
                                valid_reg[hit_idx_reg] <= 1'b0;
                                dirty_reg[hit_idx_reg] <= 1'b0;
                                page_reg[hit_idx_reg] <= '0;
                                if (member_reg[hit_idx_reg])
                                begin
                                    for (int i = 0; i < FRAME_COUNT; i++)
                                    begin
                                        age_reg[i] <= age_after_take(age_reg[i],
                                            member_reg[i], age_reg[hit_idx_reg]);
                                    end
                                    member_reg[hit_idx_reg] <= 1'b0;
                                    age_reg[hit_idx_reg] <= '0;
                                end
                                if (fq_count_reg != CNT_W'(FRAME_COUNT))
                                begin
                                    fq_reg[fq_tail_c] <= hit_idx_reg;
                                    fq_count_reg <= fq_count_reg + 1'b1;
                                end
                            end
                        end
                        pfpm_pkg::CMD_FLUSH:
                        begin
                            if (hit_reg)
                            begin
                                ok_reg <= 1'b1;
                                fi_reg <= FW'(hit_idx_reg);
                                rp_reg <= pg_reg;
                                wb_reg <= 1'b1;
                                wbp_reg <= pg_reg;
                                dirty_reg[hit_idx_reg] <= 1'b0;
                            end
                        end
                        default:
                        begin
                            ok_reg <= 1'b0;
                        end
                    endcase
                end
            end
            if (cmd.scan_step)
            begin
                // one valid frame per step; an empty pool gives a single failure
                if (valid_reg[scan_reg])
                begin
                    done_reg <= 1'b1;
                    ok_reg <= 1'b1;
                    fi_reg <= FW'(scan_reg);
                    rp_reg <= page_reg[scan_reg];
                    wb_reg <= 1'b1;
                    wbp_reg <= page_reg[scan_reg];
                    ld_reg <= 1'b0;
                    clr_reg <= 1'b0;
                    last_reg <= scan_at_end;
                    dirty_reg[scan_reg] <= 1'b0;
                end
                else if (scan_at_end && !any_valid_c)
                begin
                    done_reg <= 1'b1;
                    ok_reg <= 1'b0;
                    fi_reg <= '0;
                    rp_reg <= '0;
                    wb_reg <= 1'b0;
                    wbp_reg <= '0;
                    ld_reg <= 1'b0;
                    clr_reg <= 1'b0;
                    last_reg <= 1'b1;
                end
            end
        end
    end

    // request capture, lookup and scan position
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg <= command;
            pg_reg <= page_number;
            md_reg <= mark_dirty;
        end
        if (cmd.lookup)
        begin
            hit_reg <= hit_c;
            hit_idx_reg <= hit_idx_c;
            vic_ok_reg <= vic_ok_c;
            vic_idx_reg <= vic_idx_c;
        end
        if (cmd.scan_init)
        begin
            scan_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_reg <= scan_reg + 1'b1;
        end
    end

    assign done = done_reg;
    assign success = ok_reg;
    assign frame_index = fi_reg;
    assign result_page = rp_reg;
    assign write_back = wb_reg;
    assign write_back_page = wbp_reg;
    assign load_from_disk = ld_reg;
    assign clear_frame = clr_reg;
    assign last = last_reg;

    `include "page_frame_pool_manager_assert.svh"

    `PFPM_ASSERT_ALWAYS(a_fq_bound, fq_count_reg <= CNT_W'(FRAME_COUNT),
        "free queue count out of range")
    `PFPM_ASSERT_ALWAYS(a_member_valid, (member_reg & ~valid_reg) == '0,
        "lru member on an unmapped frame")
    `PFPM_ASSERT_NEXT(a_exec_done, cmd.execute, done, "execute gave no result")

endmodule

`default_nettype wire

/* sv/page_frame_pool_manager.sv */
// ----------------------------------------------------------------------------
// page_frame_pool_manager
// buffer pool manager with free queue and lru replacement over page frames
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Single-result
// commands pass through capture, lookup (all frames compared in parallel,
// lru victim found at once) and execute; the result shows in the cycle after
// execute with done high for one cycle, and busy drops as it appears. Flush-all
// walks the frame table one frame per cycle up to the highest mapped frame
// and gives one result per mapped frame, last marking the final one (a single
// failure result with an empty pool).
// The receiver cannot stall: every done pulse must be taken when it shows.
// Configuration writes are taken at any time but belong in idle periods.
`default_nettype none

module page_frame_pool_manager #(
    parameter int FRAME_COUNT = 16,
    parameter int PIN_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request port
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [pfpm_pkg::CMD_W-1:0]    command,
    input  wire logic [pfpm_pkg::PAGE_W-1:0]   page_number,
    input  wire logic                          mark_dirty,
    // configuration write port
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [10:0]                   cfg_data,
    // result port
    output logic                               done,
    output logic                               success,
    output logic [pfpm_pkg::FRAME_W-1:0]       frame_index,
    output logic [pfpm_pkg::PAGE_W-1:0]        result_page,
    output logic                               write_back,
    output logic [pfpm_pkg::PAGE_W-1:0]        write_back_page,
    output logic                               load_from_disk,
    output logic                               clear_frame,
    output logic                               last
);

    pfpm_pkg::pfpm_cmd_t  cmd;
    pfpm_pkg::pfpm_stat_t stat;

    // sequencer
    pfpm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    // frame tables and result register
    pfpm_dp #(
        .FRAME_COUNT (FRAME_COUNT),
        .PIN_BITS    (PIN_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_write       (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .command         (command),
        .page_number     (page_number),
        .mark_dirty      (mark_dirty),
        .done            (done),
        .success         (success),
        .frame_index     (frame_index),
        .result_page     (result_page),
        .write_back      (write_back),
        .write_back_page (write_back_page),
        .load_from_disk  (load_from_disk),
        .clear_frame     (clear_frame),
        .last            (last)
    );

endmodule

`default_nettype wire

/* tb/pfpm_checker.sv */
// ----------------------------------------------------------------------------
// pfpm_checker
// watches the request, config and result ports of the pool manager, keeps
// its own copy of the frame table and compares every result in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfpm_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire logic [pfpm_pkg::CMD_W-1:0]  command,
    input  wire logic [pfpm_pkg::PAGE_W-1:0] page_number,
    input  wire logic                        mark_dirty,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [10:0]                 cfg_data,
    input  wire logic                        done,
    input  wire logic                        success,
    input  wire logic [pfpm_pkg::FRAME_W-1:0] frame_index,
    input  wire logic [pfpm_pkg::PAGE_W-1:0] result_page,
    input  wire logic                        write_back,
    input  wire logic [pfpm_pkg::PAGE_W-1:0] write_back_page,
    input  wire logic                        load_from_disk,
    input  wire logic                        clear_frame,
    input  wire logic                        last,
    output int                               errors,
    output int                               outstanding
);

    localparam int FRAMES = 16;
    localparam logic [15:0] PIN_MAX = 16'hFFFF;

    typedef struct packed {
        logic                         ok;
        logic [pfpm_pkg::FRAME_W-1:0] frame;
        logic [pfpm_pkg::PAGE_W-1:0]  page;
        logic                         wb;
        logic [pfpm_pkg::PAGE_W-1:0]  wb_page;
        logic                         load;
        logic                         clr;
        logic                         lst;
    } pool_result_t;

    pool_result_t pending_results[$];

    logic [pfpm_pkg::PAGE_W-1:0] fr_page [FRAMES];
    logic              fr_valid[FRAMES];
    logic              fr_dirty[FRAMES];
    logic [15:0]       fr_pins [FRAMES];
    int                age     [FRAMES];
    logic              in_lru  [FRAMES];
    int                free_list[FRAMES];
    int                free_head;
    int                free_count;
    logic [10:0]       stride;
    logic [pfpm_pkg::PAGE_W-1:0] next_id;

    function automatic void clear_table();
        for (int i = 0; i < FRAMES; i++)
        begin
            fr_page[i] = '0;
            fr_valid[i] = 1'b0;
            fr_dirty[i] = 1'b0;
            fr_pins[i] = '0;
            age[i] = 0;
            in_lru[i] = 1'b0;
            free_list[i] = i;
        end
        free_head = 0;
        free_count = FRAMES;
        stride = 11'd1;
        next_id = '0;
    endfunction

    function automatic int lookup(logic [pfpm_pkg::PAGE_W-1:0] p);
        for (int i = 0; i < FRAMES; i++)
            if (fr_valid[i] && fr_page[i] == p)
                return i;
        return -1;
    endfunction

    function automatic void lru_drop(int f);
        if (!in_lru[f])
            return;
        for (int i = 0; i < FRAMES; i++)
            if (in_lru[i] && age[i] > age[f])
                age[i]--;
        in_lru[f] = 1'b0;
        age[f] = 0;
    endfunction

    function automatic void lru_add(int f);
        int n;
        n = 0;
        if (in_lru[f])
            return;
        for (int i = 0; i < FRAMES; i++)
            if (in_lru[i])
                n++;
        age[f] = n;
        in_lru[f] = 1'b1;
    endfunction

    // free list first, else oldest unpinned frame (evicted)
    function automatic int take_frame(output logic wb,
                                      output logic [pfpm_pkg::PAGE_W-1:0] wbp);
        int f;
        wb = 1'b0;
        wbp = '0;
        if (free_count > 0)
        begin
            f = free_list[free_head];
            free_head = (free_head + 1) % FRAMES;
            free_count--;
            return f;
        end
        for (int i = 0; i < FRAMES; i++)
        begin
            if (in_lru[i] && age[i] == 0)
            begin
                lru_drop(i);
                if (fr_dirty[i])
                begin
                    wb = 1'b1;
                    wbp = fr_page[i];
                end
                fr_valid[i] = 1'b0;
                fr_dirty[i] = 1'b0;
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void queue_result(logic ok, int f, logic [pfpm_pkg::PAGE_W-1:0] p,
                                         logic wb, logic [pfpm_pkg::PAGE_W-1:0] wbp,
                                         logic ld, logic cl, logic ls);
        pool_result_t r;
        r.ok = ok;
        r.frame = pfpm_pkg::FRAME_W'(f);
        r.page = p;
        r.wb = wb;
        r.wb_page = wbp;
        r.load = ld;
        r.clr = cl;
        r.lst = ls;
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void map_page(int f, logic [pfpm_pkg::PAGE_W-1:0] p);
        fr_page[f] = p;
        fr_valid[f] = 1'b1;
        fr_dirty[f] = 1'b0;
        fr_pins[f] = 16'd1;
        lru_drop(f);
    endfunction

    function automatic void apply_request(logic [pfpm_pkg::CMD_W-1:0] c,
                                          logic [pfpm_pkg::PAGE_W-1:0] p, logic md);
        int f;
        int k;
        logic wb;
        logic [pfpm_pkg::PAGE_W-1:0] wbp;
        logic [pfpm_pkg::PAGE_W-1:0] id;
        case (c)
            pfpm_pkg::CMD_FETCH:
            begin
                f = lookup(p);
                if (f >= 0)
                begin
                    if (fr_pins[f] < PIN_MAX)
                        fr_pins[f]++;
                    lru_drop(f);
                    queue_result(1, f, p, 0, 0, 0, 0, 1);
                end
                else
                begin
                    f = take_frame(wb, wbp);
                    if (f < 0)
                        queue_result(0, 0, 0, 0, 0, 0, 0, 1);
                    else
                    begin
                        map_page(f, p);
                        queue_result(1, f, p, wb, wbp, 1, 0, 1);
                    end
                end
            end
            pfpm_pkg::CMD_NEW:
            begin
                id = next_id;
                next_id = next_id + pfpm_pkg::PAGE_W'(stride);
                f = take_frame(wb, wbp);
                if (f < 0)
                    queue_result(0, 0, 0, 0, 0, 0, 0, 1);
                else
                begin
                    map_page(f, id);
                    queue_result(1, f, id, wb, wbp, 0, 1, 1);
                end
            end
            pfpm_pkg::CMD_UNPIN:
            begin
                f = lookup(p);
                if (f < 0)
                    queue_result(0, 0, 0, 0, 0, 0, 0, 1);
                else
                begin
                    if (md)
                        fr_dirty[f] = 1'b1;
                    if (fr_pins[f] == 0)
                        queue_result(0, f, p, 0, 0, 0, 0, 1);
                    else
                    begin
                        fr_pins[f]--;
                        if (fr_pins[f] == 0)
                            lru_add(f);
                        queue_result(1, f, p, 0, 0, 0, 0, 1);
                    end
                end
            end
            pfpm_pkg::CMD_DELETE:
            begin
                f = lookup(p);
                if (f < 0)
                    queue_result(1, 0, 0, 0, 0, 0, 0, 1);
                else if (fr_pins[f] != 0)
                    queue_result(0, f, p, 0, 0, 0, 0, 1);
                else
                begin
                    wb = fr_dirty[f];
                    fr_valid[f] = 1'b0;
                    fr_dirty[f] = 1'b0;
                    fr_page[f] = '0;
                    lru_drop(f);
                    if (free_count < FRAMES)
                    begin
                        free_list[(free_head + free_count) % FRAMES] = f;
                        free_count++;
                    end
                    queue_result(1, f, 0, wb, wb ? p : '0, 0, 1, 1);
                end
            end
            pfpm_pkg::CMD_FLUSH:
            begin
                f = lookup(p);
                if (f < 0)
                    queue_result(0, 0, 0, 0, 0, 0, 0, 1);
                else
                begin
                    fr_dirty[f] = 1'b0;
                    queue_result(1, f, p, 1, p, 0, 0, 1);
                end
            end
            pfpm_pkg::CMD_FLUSH_ALL:
            begin
                k = 0;
                for (int i = 0; i < FRAMES; i++)
                begin
                    if (fr_valid[i])
                    begin
                        fr_dirty[i] = 1'b0;
                        queue_result(1, i, fr_page[i], 1, fr_page[i], 0, 0, 0);
                        k++;
                    end
                end
                if (k == 0)
                    queue_result(0, 0, 0, 0, 0, 0, 0, 1);
                else
                    pending_results[pending_results.size()-1].lst = 1'b1;
            end
            default:
                queue_result(0, 0, 0, 0, 0, 0, 0, 1);
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pool_result_t want;
        pool_result_t got;
        if (!rst_n)
        begin
            clear_table();
            pending_results.delete();
            errors = 0;
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                got = '{success, frame_index, result_page, write_back, write_back_page,
                        load_from_disk, clear_frame, last};
                if (pending_results.size() == 0)
                    report_mismatch("result with no request waiting");
                else
                begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (got !== want)
                        report_mismatch($sformatf("got %p want %p", got, want));
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == pfpm_pkg::CFG_INSTANCE_COUNT)
                    stride = cfg_data;
                else
                    next_id = pfpm_pkg::PAGE_W'(cfg_data[9:0]);
            end
            if (start && !busy)
                apply_request(command, page_number, mark_dirty);
            outstanding = pending_results.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the page frame pool manager: directed corner
// requests, then random traffic over a small page set, across config phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [pfpm_pkg::CMD_W-1:0]   command = pfpm_pkg::CMD_FETCH;
    logic [pfpm_pkg::PAGE_W-1:0]  page_number = '0;
    logic                         mark_dirty = 1'b0;
    logic                         cfg_we = 1'b0;
    logic                         cfg_index = pfpm_pkg::CFG_INSTANCE_COUNT;
    logic [10:0]                  cfg_data = '0;
    logic                         done;
    logic                         success;
    logic [pfpm_pkg::FRAME_W-1:0] frame_index;
    logic [pfpm_pkg::PAGE_W-1:0]  result_page;
    logic                         write_back;
    logic [pfpm_pkg::PAGE_W-1:0]  write_back_page;
    logic                         load_from_disk;
    logic                         clear_frame;
    logic                         last;
    int                           errors;
    int                           outstanding;
    bit                           allow_idle = 1'b1;

    // 2 ns clock
    always #1 clk = ~clk;

    page_frame_pool_manager dut (.*);

    pfpm_checker checker_i (.*);

    // idle gap on the request side, about one request in four
    task automatic maybe_idle();
        int n;
        if (allow_idle && $urandom_range(99) < 25)
        begin
            n = $urandom_range(6, 1);
            @(negedge clk);
            start <= 1'b0;
            command <= pfpm_pkg::CMD_W'($urandom());
            page_number <= pfpm_pkg::PAGE_W'($urandom());
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // present one request and hold it until the block takes it
    task automatic send_request(logic [pfpm_pkg::CMD_W-1:0] c,
                                logic [pfpm_pkg::PAGE_W-1:0] p, logic md);
        @(negedge clk);
        start <= 1'b1;
        command <= c;
        page_number <= p;
        mark_dirty <= md;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        maybe_idle();
    endtask

    // settle the block, then write one register
    task automatic write_reg(logic idx, logic [10:0] val);
        @(negedge clk);
        start <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (outstanding == 0 && !busy)
                break;
        end
        repeat (25) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // page ids mostly from a small set so hits, unpins and deletes land
    function automatic logic [pfpm_pkg::PAGE_W-1:0] pick_page();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return pfpm_pkg::PAGE_W'($urandom_range(24));
        else if (r < 85)
            return {pfpm_pkg::PAGE_W{1'b1}};
        else if (r < 90)
            return pfpm_pkg::PAGE_W'($urandom_range(4100, 1020));
        return pfpm_pkg::PAGE_W'($urandom());
    endfunction

    function automatic logic [pfpm_pkg::CMD_W-1:0] pick_command();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return pfpm_pkg::CMD_FETCH;
        else if (r < 45)
            return pfpm_pkg::CMD_NEW;
        else if (r < 75)
            return pfpm_pkg::CMD_UNPIN;
        else if (r < 85)
            return pfpm_pkg::CMD_DELETE;
        else if (r < 92)
            return pfpm_pkg::CMD_FLUSH;
        else if (r < 96)
            return pfpm_pkg::CMD_FLUSH_ALL;
        return pfpm_pkg::CMD_W'($urandom_range(7, 6));
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
        begin
            // one long burst with no gaps at all
            allow_idle = !(i >= count / 3 && i < count / 2);
            send_request(pick_command(), pick_page(), 1'(($urandom())));
        end
        allow_idle = 1'b1;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(pfpm_pkg::CFG_INSTANCE_COUNT, 11'd1);
        write_reg(pfpm_pkg::CFG_INSTANCE_NUMBER, 11'd3);

        // flush-all on an empty pool
        send_request(pfpm_pkg::CMD_FLUSH_ALL, '0, 1'b0);
        // directed: extremes, hits, pin corner cases, unmapped cases
        send_request(pfpm_pkg::CMD_FETCH, '0, 1'b0);
        send_request(pfpm_pkg::CMD_FETCH, {pfpm_pkg::PAGE_W{1'b1}}, 1'b0);
        send_request(pfpm_pkg::CMD_FETCH, 31'd5, 1'b0);
        send_request(pfpm_pkg::CMD_FETCH, 31'd5, 1'b0);
        send_request(pfpm_pkg::CMD_UNPIN, 31'd5, 1'b1);
        send_request(pfpm_pkg::CMD_UNPIN, 31'd5, 1'b0);
        send_request(pfpm_pkg::CMD_UNPIN, 31'd5, 1'b0);
        send_request(pfpm_pkg::CMD_UNPIN, 31'd99, 1'b1);
        send_request(pfpm_pkg::CMD_NEW, '0, 1'b0);
        send_request(pfpm_pkg::CMD_NEW, '0, 1'b0);
        send_request(pfpm_pkg::CMD_DELETE, {pfpm_pkg::PAGE_W{1'b1}}, 1'b0);
        send_request(pfpm_pkg::CMD_UNPIN, {pfpm_pkg::PAGE_W{1'b1}}, 1'b0);
        send_request(pfpm_pkg::CMD_DELETE, {pfpm_pkg::PAGE_W{1'b1}}, 1'b0);
        send_request(pfpm_pkg::CMD_DELETE, 31'd1234, 1'b0);
        send_request(pfpm_pkg::CMD_FLUSH, 31'd5, 1'b0);
        send_request(pfpm_pkg::CMD_FLUSH, 31'd77, 1'b0);
        send_request(3'd6, 31'd5, 1'b1);
        send_request(3'd7, '0, 1'b0);
        // exhaust the pool: unpinned frame evicted, then nothing left
        for (int i = 0; i < 14; i++)
            send_request(pfpm_pkg::CMD_FETCH, 31'(100 + i), 1'b0);
        send_request(pfpm_pkg::CMD_NEW, '0, 1'b0);
        send_request(pfpm_pkg::CMD_FLUSH_ALL, '0, 1'b0);

        // zero stride: every new page gets the same id
        write_reg(pfpm_pkg::CFG_INSTANCE_COUNT, 11'd0);
        random_phase(60);

        write_reg(pfpm_pkg::CFG_INSTANCE_COUNT, 11'h7FF);
        write_reg(pfpm_pkg::CFG_INSTANCE_NUMBER, 11'h7FF);
        random_phase(60);

        write_reg(pfpm_pkg::CFG_INSTANCE_COUNT, 11'd1024);
        write_reg(pfpm_pkg::CFG_INSTANCE_NUMBER, 11'd0);
        random_phase(60);

        write_reg(pfpm_pkg::CFG_INSTANCE_COUNT, 11'd1);
        write_reg(pfpm_pkg::CFG_INSTANCE_NUMBER, 11'd1);
        random_phase(170);

        @(negedge clk);
        start <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (outstanding == 0 && !busy)
                break;
        end
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial
    begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
